### rtl/core/midpoint_ellipse_rasterizer_assert.svh
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer assertion macros
// Concurrent assertion forms used by the rasterizer controller.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MER_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rasterizer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define MER_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rasterizer assertion failed");

`endif

### rtl/core/mer_pkg.sv
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer package
// Field widths, operation codes and the controller/datapath command types.
// ----------------------------------------------------------------------------
package mer_pkg;

    localparam int RAD_IN_W = 10;
    localparam int CTR_W    = 12;
    localparam int PT_W     = 13;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Register index as decoded from paddr bit 2.
    localparam logic REG_CENTER_X = 1'b0;
    localparam logic REG_CENTER_Y = 1'b1;

    // Operand pairs for the shared multiplier.
    typedef enum logic [3:0] {
        MUL_RX_RX,
        MUL_Y_Y,
        MUL_RXSQ_Y,
        MUL_RYSQ_T,
        MUL_TLO_T,
        MUL_THI_T,
        MUL_RXSQ_YM,
        MUL_TLO_YM,
        MUL_THI_YM,
        MUL_RXSQ_RYLO,
        MUL_RXSQ_RYHI
    } t_mul_op;

    // What to do with the product registered in the previous cycle.
    typedef enum logic [3:0] {
        WB_NONE,
        WB_RXSQ,
        WB_RYSQ,
        WB_START,
        WB_TMP,
        WB_DEC_LOAD,
        WB_DEC_ADD_S2R,
        WB_DEC_ADD_S2,
        WB_DEC_ADD_S2R2,
        WB_DEC_SUB_S2,
        WB_DEC_SUB_SR2
    } t_wb_op;

    typedef struct packed {
        logic       load;
        t_mul_op    mul;
        t_wb_op     wb;
        logic       inc_x;
        logic       dec_y;
        logic       dec_step;
        logic       use_rx;
        logic       add_gx;
        logic       sub_gy;
        logic       emit;
        logic [1:0] pt_idx;
        logic       fin;
    } t_dp_cmd;

    typedef struct packed {
        logic dec_neg;
        logic dec_zero;
        logic gx_lt_gy;
        logic y_zero;
        logic out_free;
    } t_dp_sts;

endpackage

### rtl/core/mer_if.sv
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer channels
// Valid/ready channels for command items and for outline points.
// ----------------------------------------------------------------------------
interface mer_in_if;
    import mer_pkg::*;

    logic                valid;
    logic                ready;
    logic                operation;
    logic [RAD_IN_W-1:0] radius_x;
    logic [RAD_IN_W-1:0] radius_y;

    modport source (output valid, output operation, output radius_x, output radius_y,
                    input ready);
    modport sink   (input valid, input operation, input radius_x, input radius_y,
                    output ready);
endinterface

interface mer_out_if;
    import mer_pkg::*;

    logic                   valid;
    logic                   ready;
    logic signed [PT_W-1:0] point_x;
    logic signed [PT_W-1:0] point_y;
    logic                   last_of_set;
    logic                   finished;

    modport source (output valid, output point_x, output point_y, output last_of_set,
                    output finished, input ready);
    modport sink   (input valid, input point_x, input point_y, input last_of_set,
                    input finished, output ready);
endinterface

### rtl/core/mer_ctrl.sv
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer controller
// Sequences squaring, stepping, region change and point emission.
// ----------------------------------------------------------------------------
`include "midpoint_ellipse_rasterizer_assert.svh"

module mer_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_op,
    output logic             o_in_ready,
    output mer_pkg::t_dp_cmd o_cmd,
    input  mer_pkg::t_dp_sts i_sts
);
    import mer_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_SQ0, S_SQ1, S_SQ2, S_SQ3,
        S_STEP_XY, S_STEP_DEC, S_CHECK,
        S_C0, S_C1, S_C2, S_C3, S_C4, S_C5, S_C6, S_C7, S_C8, S_C9, S_C10,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PH_IDLE, PH_R1, PH_R2, PH_DONE
    } t_phase;

    t_state     r_state;
    t_phase     r_phase;
    logic [1:0] r_pt;

    logic in_r1;
    logic inc_x;
    logic dec_y;

    assign in_r1 = (r_phase == PH_R1);
    // Region 1 always moves x; region 2 always moves y.
    assign inc_x = in_r1 ? 1'b1 : (i_sts.dec_neg || i_sts.dec_zero);
    assign dec_y = in_r1 ? !i_sts.dec_neg : 1'b1;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd        = '0;
        o_cmd.mul    = MUL_RX_RX;
        o_cmd.wb     = WB_NONE;
        o_cmd.pt_idx = r_pt;
        o_cmd.fin    = (r_phase == PH_DONE);
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_in_valid && (i_in_op == OP_START);
            end
            S_SQ0: o_cmd.mul = MUL_RX_RX;
            S_SQ1: begin
                o_cmd.mul = MUL_Y_Y;
                o_cmd.wb  = WB_RXSQ;
            end
            S_SQ2: begin
                o_cmd.mul = MUL_RXSQ_Y;
                o_cmd.wb  = WB_RYSQ;
            end
            S_SQ3: o_cmd.wb = WB_START;
            S_STEP_XY: begin
                o_cmd.inc_x = inc_x;
                o_cmd.dec_y = dec_y;
            end
            S_STEP_DEC: begin
                o_cmd.dec_step = 1'b1;
                o_cmd.use_rx   = !in_r1;
                o_cmd.add_gx   = in_r1 ? 1'b1 : inc_x;
                o_cmd.sub_gy   = in_r1 ? dec_y : 1'b1;
            end
            S_CHECK: ;
            S_C0: o_cmd.mul = MUL_RYSQ_T;
            S_C1: o_cmd.wb  = WB_TMP;
            S_C2: o_cmd.mul = MUL_TLO_T;
            S_C3: begin
                o_cmd.mul = MUL_THI_T;
                o_cmd.wb  = WB_DEC_LOAD;
            end
            S_C4: begin
                o_cmd.mul = MUL_RXSQ_YM;
                o_cmd.wb  = WB_DEC_ADD_S2R;
            end
            S_C5: o_cmd.wb  = WB_TMP;
            S_C6: o_cmd.mul = MUL_TLO_YM;
            S_C7: begin
                o_cmd.mul = MUL_THI_YM;
                o_cmd.wb  = WB_DEC_ADD_S2;
            end
            S_C8: begin
                o_cmd.mul = MUL_RXSQ_RYLO;
                o_cmd.wb  = WB_DEC_ADD_S2R2;
            end
            S_C9: begin
                o_cmd.mul = MUL_RXSQ_RYHI;
                o_cmd.wb  = WB_DEC_SUB_S2;
            end
            S_C10: o_cmd.wb = WB_DEC_SUB_SR2;
            S_EMIT: o_cmd.emit = i_sts.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= PH_IDLE;
            r_pt    <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (i_in_op == OP_START) begin
                            r_phase <= PH_R1;
                            r_state <= S_SQ0;
                        end else if (r_phase == PH_R1 || r_phase == PH_R2) begin
                            r_state <= S_STEP_XY;
                        end
                    end
                end
                S_SQ0:      r_state <= S_SQ1;
                S_SQ1:      r_state <= S_SQ2;
                S_SQ2:      r_state <= S_SQ3;
                S_SQ3:      r_state <= S_CHECK;
                S_STEP_XY:  r_state <= S_STEP_DEC;
                S_STEP_DEC: r_state <= S_CHECK;
                S_CHECK: begin
                    if (in_r1) begin
                        r_state <= i_sts.gx_lt_gy ? S_EMIT : S_C0;
                    end else begin
                        if (i_sts.y_zero) begin
                            r_phase <= PH_DONE;
                        end
                        r_state <= S_EMIT;
                    end
                end
                S_C0: r_state <= S_C1;
                S_C1: r_state <= S_C2;
                S_C2: r_state <= S_C3;
                S_C3: r_state <= S_C4;
                S_C4: r_state <= S_C5;
                S_C5: r_state <= S_C6;
                S_C6: r_state <= S_C7;
                S_C7: r_state <= S_C8;
                S_C8: r_state <= S_C9;
                S_C9: r_state <= S_C10;
                S_C10: begin
                    r_phase <= i_sts.y_zero ? PH_DONE : PH_R2;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (i_sts.out_free) begin
                        r_pt <= r_pt + 2'd1;
                        if (&r_pt) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // A set emitted while still in region 1 means the gradients have not crossed.
    `MER_ASSERT_IMP(a_r1_grad_order, i_clk, i_rst_n, (r_state == S_EMIT && r_phase == PH_R1), i_sts.gx_lt_gy)
    // A step only runs on an ellipse that is still open.
    `MER_ASSERT_IMP(a_step_open, i_clk, i_rst_n, (r_state == S_STEP_XY), (r_phase == PH_R1 || r_phase == PH_R2))
    // A finished arc has walked y down to zero.
    `MER_ASSERT_IMP(a_done_y_zero, i_clk, i_rst_n, (r_phase == PH_DONE), i_sts.y_zero)

endmodule

### rtl/core/mer_dp.sv
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer datapath
// Coordinate, gradient and decision registers, shared multiplier, point output.
// ----------------------------------------------------------------------------
module mer_dp #(
    parameter int RADIUS_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mer_pkg::t_dp_cmd                    i_cmd,
    output mer_pkg::t_dp_sts                    o_sts,
    input  logic [mer_pkg::RAD_IN_W-1:0]        i_radius_x,
    input  logic [mer_pkg::RAD_IN_W-1:0]        i_radius_y,
    input  logic signed [mer_pkg::CTR_W-1:0]    i_center_x,
    input  logic signed [mer_pkg::CTR_W-1:0]    i_center_y,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [mer_pkg::PT_W-1:0]     o_point_x,
    output logic signed [mer_pkg::PT_W-1:0]     o_point_y,
    output logic                                o_last_of_set,
    output logic                                o_finished
);
    import mer_pkg::*;

    localparam int R_W  = RADIUS_BITS;
    localparam int SQ_W = 2 * RADIUS_BITS;
    localparam int G_W  = 3 * RADIUS_BITS + 2;
    localparam int D_W  = (4 * RADIUS_BITS + 6 > 64) ? 64 : 4 * RADIUS_BITS + 6;
    localparam int MA_W = SQ_W;
    localparam int MB_W = RADIUS_BITS + 2;
    localparam int P_W  = MA_W + MB_W;
    localparam int X_W  = P_W + SQ_W + 2;

    logic [R_W-1:0]  r_rad_x;
    logic [R_W-1:0]  r_x;
    logic [R_W-1:0]  r_y;
    logic [SQ_W-1:0] r_rx_sq;
    logic [SQ_W-1:0] r_ry_sq;
    logic [G_W-1:0]  r_gx;
    logic [G_W-1:0]  r_gy;
    logic [D_W-1:0]  r_dec;
    logic [P_W-1:0]  r_prod;
    logic [P_W-1:0]  r_tmp;

    logic                r_out_valid;
    logic [PT_W-1:0]     r_px;
    logic [PT_W-1:0]     r_py;
    logic                r_last;
    logic                r_fin;

    logic [MA_W-1:0] mul_a;
    logic [MB_W-1:0] mul_b;
    logic [R_W:0]    t_val;
    logic [R_W-1:0]  ym;
    logic [X_W-1:0]  prod_x;
    logic [SQ_W-1:0] sq_sel;
    logic [D_W-1:0]  dec_step;
    logic [PT_W-1:0] cx13;
    logic [PT_W-1:0] cy13;
    logic [PT_W-1:0] x13;
    logic [PT_W-1:0] y13;

    // 2x+1, and y-1 with the y = 0 case folded to 1 since only its square is used.
    assign t_val  = {r_x, 1'b1};
    assign ym     = (r_y == '0) ? R_W'(1) : r_y - R_W'(1);
    assign prod_x = X_W'(r_prod);

    always_comb begin
        mul_a = r_rx_sq;
        mul_b = MB_W'(r_y);
        unique case (i_cmd.mul)
            MUL_RX_RX: begin
                mul_a = MA_W'(r_rad_x);
                mul_b = MB_W'(r_rad_x);
            end
            MUL_Y_Y: begin
                mul_a = MA_W'(r_y);
                mul_b = MB_W'(r_y);
            end
            MUL_RXSQ_Y: begin
                mul_a = r_rx_sq;
                mul_b = MB_W'(r_y);
            end
            MUL_RYSQ_T: begin
                mul_a = r_ry_sq;
                mul_b = MB_W'(t_val);
            end
            MUL_TLO_T: begin
                mul_a = r_tmp[SQ_W-1:0];
                mul_b = MB_W'(t_val);
            end
            MUL_THI_T: begin
                mul_a = MA_W'(r_tmp[P_W-1:SQ_W]);
                mul_b = MB_W'(t_val);
            end
            MUL_RXSQ_YM: begin
                mul_a = r_rx_sq;
                mul_b = MB_W'(ym);
            end
            MUL_TLO_YM: begin
                mul_a = r_tmp[SQ_W-1:0];
                mul_b = MB_W'(ym);
            end
            MUL_THI_YM: begin
                mul_a = MA_W'(r_tmp[P_W-1:SQ_W]);
                mul_b = MB_W'(ym);
            end
            MUL_RXSQ_RYLO: begin
                mul_a = r_rx_sq;
                mul_b = MB_W'(r_ry_sq[R_W-1:0]);
            end
            MUL_RXSQ_RYHI: begin
                mul_a = r_rx_sq;
                mul_b = MB_W'(r_ry_sq[SQ_W-1:R_W]);
            end
            default: ;
        endcase
    end

    // Decision update of one step: all terms carry the factor of four.
    assign sq_sel   = i_cmd.use_rx ? r_rx_sq : r_ry_sq;
    assign dec_step = r_dec + D_W'({sq_sel, 2'b00})
                    + (i_cmd.add_gx ? D_W'({r_gx, 2'b00}) : '0)
                    - (i_cmd.sub_gy ? D_W'({r_gy, 2'b00}) : '0);

    always_ff @(posedge i_clk) begin
        r_prod <= P_W'(mul_a) * P_W'(mul_b);

        if (i_cmd.load) begin
            r_rad_x <= R_W'(i_radius_x);
            r_y     <= R_W'(i_radius_y);
            r_x     <= '0;
            r_gx    <= '0;
        end
        if (i_cmd.inc_x) begin
            r_x  <= r_x + R_W'(1);
            r_gx <= r_gx + G_W'({r_ry_sq, 1'b0});
        end
        if (i_cmd.dec_y) begin
            r_y  <= r_y - R_W'(1);
            r_gy <= r_gy - G_W'({r_rx_sq, 1'b0});
        end
        if (i_cmd.dec_step) begin
            r_dec <= dec_step;
        end

        unique case (i_cmd.wb)
            WB_NONE: ;
            WB_RXSQ: r_rx_sq <= r_prod[SQ_W-1:0];
            WB_RYSQ: r_ry_sq <= r_prod[SQ_W-1:0];
            WB_START: begin
                r_gy  <= G_W'({r_prod, 1'b0});
                r_dec <= D_W'({r_ry_sq, 2'b00}) - D_W'(prod_x << 2) + D_W'(r_rx_sq);
            end
            WB_TMP:          r_tmp <= r_prod;
            WB_DEC_LOAD:     r_dec <= D_W'(prod_x);
            WB_DEC_ADD_S2R:  r_dec <= r_dec + D_W'(prod_x << SQ_W);
            WB_DEC_ADD_S2:   r_dec <= r_dec + D_W'(prod_x << 2);
            WB_DEC_ADD_S2R2: r_dec <= r_dec + D_W'(prod_x << (SQ_W + 2));
            WB_DEC_SUB_S2:   r_dec <= r_dec - D_W'(prod_x << 2);
            WB_DEC_SUB_SR2:  r_dec <= r_dec - D_W'(prod_x << (R_W + 2));
            default: ;
        endcase
    end

    // Points come out in the order (+x,+y), (-x,+y), (+x,-y), (-x,-y).
    assign cx13 = {i_center_x[CTR_W-1], i_center_x};
    assign cy13 = {i_center_y[CTR_W-1], i_center_y};
    assign x13  = PT_W'(r_x);
    assign y13  = PT_W'(r_y);

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_px   <= i_cmd.pt_idx[0] ? cx13 - x13 : cx13 + x13;
            r_py   <= i_cmd.pt_idx[1] ? cy13 - y13 : cy13 + y13;
            r_last <= &i_cmd.pt_idx;
            r_fin  <= i_cmd.fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_point_x     = r_px;
    assign o_point_y     = r_py;
    assign o_last_of_set = r_last;
    assign o_finished    = r_fin;

    assign o_sts.dec_neg  = r_dec[D_W-1];
    assign o_sts.dec_zero = (r_dec == '0);
    assign o_sts.gx_lt_gy = (r_gx < r_gy);
    assign o_sts.y_zero   = (r_y == '0);
    assign o_sts.out_free = !r_out_valid || i_out_ready;

endmodule

### rtl/core/midpoint_ellipse_rasterizer.sv
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer
// Quarter-arc midpoint ellipse outline with four-way symmetric point output.
// ----------------------------------------------------------------------------
// Step item: S_STEP_XY, S_STEP_DEC and S_CHECK update, then four points go out before ready returns.
// Start item: squaring in S_SQ0 to S_SQ3 on the shared multiplier, then S_CHECK and four points.
// Entering region 2 adds the S_C0 to S_C10 multiplier sequence for the new decision.
// A step with no open ellipse is accepted and dropped; output stalls hold each point in S_EMIT.
// Reset clears the controller, the output valid flag and both center registers.
module midpoint_ellipse_rasterizer #(
    parameter int RADIUS_BITS = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    mer_in_if.sink                         i_item,
    mer_out_if.source                      o_point,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mer_pkg::APB_AW-1:0]     paddr,
    input  logic [mer_pkg::APB_DW-1:0]     pwdata,
    output logic [mer_pkg::APB_DW-1:0]     prdata,
    output logic                           pready
);
    import mer_pkg::*;

    logic signed [CTR_W-1:0] r_center_x;
    logic signed [CTR_W-1:0] r_center_y;

    t_dp_cmd cmd;
    t_dp_sts sts;

    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_CENTER_X) begin
                r_center_x <= pwdata[CTR_W-1:0];
            end else begin
                r_center_y <= pwdata[CTR_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_CENTER_Y)
                  ? {{(APB_DW - CTR_W){r_center_y[CTR_W-1]}}, r_center_y}
                  : {{(APB_DW - CTR_W){r_center_x[CTR_W-1]}}, r_center_x};

    mer_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .i_in_op    (i_item.operation),
        .o_in_ready (i_item.ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    mer_dp #(
        .RADIUS_BITS (RADIUS_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_radius_x    (i_item.radius_x),
        .i_radius_y    (i_item.radius_y),
        .i_center_x    (r_center_x),
        .i_center_y    (r_center_y),
        .o_out_valid   (o_point.valid),
        .i_out_ready   (o_point.ready),
        .o_point_x     (o_point.point_x),
        .o_point_y     (o_point.point_y),
        .o_last_of_set (o_point.last_of_set),
        .o_finished    (o_point.finished)
    );

endmodule
